### rtl/pnrps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnrps_pkg
// shared constants, codes and types of the per-node random packet sampler
// ----------------------------------------------------------------------------
package pnrps_pkg;

  localparam int NODES      = 16;
  localparam int MAX_WINDOW = 128;
  localparam int NODE_W     = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int POS_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  localparam logic [31:0] LFSR_TAPS    = 32'h8020_0003;
  localparam logic [31:0] SEED_RESET   = 32'd1;
  localparam logic [7:0]  TAKE_RESET   = 8'd100;
  localparam logic [7:0]  WINDOW_RESET = 8'd100;

  typedef enum logic [1:0] {
    REG_SEED    = 2'd0,
    REG_TAKE    = 2'd1,
    REG_WINDOW  = 2'd2,
    REG_UNUSED  = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD_RATE  = 2'd3
  } status_t;

  localparam logic REQ_PACKET = 1'b0;
  localparam logic REQ_RATE   = 1'b1;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [7:0]  divisor;
  } mod_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] rem;
  } mod_rsp_t;

  function automatic logic [31:0] lfsr_next(input logic [31:0] l);
    lfsr_next = (l >> 1) ^ (l[0] ? LFSR_TAPS : 32'd0);
  endfunction

endpackage

### rtl/pnrps_mod_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnrps_mod_unit
// restoring remainder of a 32-bit value by an 8-bit divisor, one bit a cycle
// ----------------------------------------------------------------------------
module pnrps_mod_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  pnrps_pkg::mod_req_t req,
  output pnrps_pkg::mod_rsp_t rsp
);

  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [31:0] dvd_r;
  logic [7:0]  div_r;
  logic [7:0]  rem_r;
  logic [8:0]  sh;
  logic [7:0]  rem_nxt;

  always_comb begin
    sh = {rem_r, dvd_r[31]};
    if (sh >= {1'b0, div_r}) begin
      rem_nxt = 8'(sh - {1'b0, div_r});
    end else begin
      rem_nxt = sh[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        dvd_r  <= req.dividend;
        div_r  <= req.divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        dvd_r <= {dvd_r[30:0], 1'b0};
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

### rtl/per_node_random_packet_sampler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_node_random_packet_sampler_top
// per-monitor random take-out-of-window packet sampler with a 16-entry monitor table
// ----------------------------------------------------------------------------
// channel  ports                                          handshake
// in       in_req_type in_node_addr in_new_take in_new_window  start & !busy
// out      out_take out_status                            out_valid, one cycle
// cfg      cfg_idx cfg_wdata                              cfg_we
//
// a packet that reads its pick row passes through the lookup, row read and bit
// select states before its result strobe; a rate change or a packet decided
// by its rate alone is answered from the lookup state. a window start draws
// take positions one after another through the shared remainder unit before
// that request's result is issued.
// synchronous reset clears the table valid bits and loads seed and defaults.
// the receiver cannot stall; busy stays high until the result is issued.
// ----------------------------------------------------------------------------
module per_node_random_packet_sampler_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_req_type,
  input  logic [31:0] in_node_addr,
  input  logic [7:0]  in_new_take,
  input  logic [7:0]  in_new_window,
  output logic        out_valid,
  output logic        out_take,
  output logic [1:0]  out_status,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [31:0] cfg_wdata
);

  localparam int N  = pnrps_pkg::NODES;
  localparam int MW = pnrps_pkg::MAX_WINDOW;
  localparam int NW = pnrps_pkg::NODE_W;
  localparam int PW = pnrps_pkg::POS_W;

  typedef enum logic [2:0] {
    S_IDLE, S_LOOK, S_READ, S_FIN, S_DRAW, S_MODW
  } state_t;

  state_t      state_r;
  logic        req_type_r;
  logic [31:0] addr_r;
  logic [7:0]  ntake_r, nwin_r;
  logic [31:0] lfsr_r;
  logic [7:0]  dflt_take_r, dflt_win_r;

  logic          valid_r [N];
  logic [31:0]   eaddr_r [N];
  logic [7:0]    etake_r [N];
  logic [7:0]    ewin_r  [N];
  logic [PW-1:0] epos_r  [N];

  logic [MW-1:0] mem [N];
  logic [MW-1:0] rd_r;
  logic [MW-1:0] row_r;
  logic          mem_we;

  logic [NW-1:0] idx_r;
  logic [7:0]    t_r;
  logic [7:0]    k_r;
  logic [PW-1:0] p_r;

  logic          out_valid_r, out_take_r;
  logic [1:0]    out_status_r;

  // table search, lowest entry wins
  logic          hit, free;
  logic [NW-1:0] hit_idx, free_idx;

  always_comb begin
    hit      = 1'b0;
    free     = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (valid_r[i] && eaddr_r[i] == addr_r) begin
        hit     = 1'b1;
        hit_idx = NW'(i);
      end
      if (!valid_r[i]) begin
        free     = 1'b1;
        free_idx = NW'(i);
      end
    end
  end

  // rate of the entry that a packet would use
  logic [NW-1:0] use_idx;
  logic [7:0]    use_t, use_w;
  logic [PW-1:0] use_p, pos_adv;
  logic [8:0]    p_inc;

  always_comb begin
    use_idx = hit ? hit_idx : free_idx;
    if (hit) begin
      use_t = etake_r[hit_idx];
      use_w = ewin_r[hit_idx];
      use_p = (9'(epos_r[hit_idx]) >= 9'(ewin_r[hit_idx])) ? '0 : epos_r[hit_idx];
    end else begin
      use_t = dflt_take_r;
      use_w = dflt_win_r;
      use_p = '0;
    end
    p_inc   = 9'(use_p) + 9'd1;
    pos_adv = (p_inc >= {1'b0, use_w}) ? '0 : PW'(p_inc);
  end

  pnrps_pkg::mod_req_t mod_req;
  pnrps_pkg::mod_rsp_t mod_rsp;
  logic [31:0]         lfsr_adv;

  assign lfsr_adv         = pnrps_pkg::lfsr_next(lfsr_r);
  assign mod_req.start    = (state_r == S_DRAW) && (k_r != t_r);
  assign mod_req.dividend = lfsr_adv;
  assign mod_req.divisor  = ewin_r[idx_r];

  pnrps_mod_unit u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  assign mem_we = (state_r == S_DRAW) && (k_r == t_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[idx_r] <= row_r;
    end
    rd_r <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      lfsr_r      <= pnrps_pkg::SEED_RESET;
      dflt_take_r <= pnrps_pkg::TAKE_RESET;
      dflt_win_r  <= pnrps_pkg::WINDOW_RESET;
      for (int i = 0; i < N; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        unique case (pnrps_pkg::reg_idx_t'(cfg_idx))
          pnrps_pkg::REG_SEED:   lfsr_r      <= cfg_wdata;
          pnrps_pkg::REG_TAKE:   dflt_take_r <= cfg_wdata[7:0];
          pnrps_pkg::REG_WINDOW: dflt_win_r  <= cfg_wdata[7:0];
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            req_type_r <= in_req_type;
            addr_r     <= in_node_addr;
            ntake_r    <= in_new_take;
            nwin_r     <= in_new_window;
            state_r    <= S_LOOK;
          end
        end
        S_LOOK: begin
          out_take_r   <= 1'b0;
          out_status_r <= pnrps_pkg::ST_OK;
          idx_r        <= use_idx;
          t_r          <= use_t;
          p_r          <= use_p;
          state_r      <= S_IDLE;
          if (req_type_r == pnrps_pkg::REQ_RATE) begin
            out_valid_r <= 1'b1;
            if (hit) begin
              etake_r[hit_idx] <= ntake_r;
              ewin_r[hit_idx]  <= nwin_r;
              epos_r[hit_idx]  <= '0;
            end else begin
              out_status_r <= pnrps_pkg::ST_NOT_FOUND;
            end
          end else if (!hit && !free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= pnrps_pkg::ST_FULL;
          end else begin
            if (!hit) begin
              valid_r[free_idx] <= 1'b1;
              eaddr_r[free_idx] <= addr_r;
              etake_r[free_idx] <= dflt_take_r;
              ewin_r[free_idx]  <= dflt_win_r;
              epos_r[free_idx]  <= '0;
            end
            priority if (use_t == 8'd0) begin
              out_valid_r <= 1'b1;
            end else if (use_t == use_w) begin
              out_valid_r <= 1'b1;
              out_take_r  <= 1'b1;
            end else if (use_t > use_w || 32'(use_w) > 32'(MW)) begin
              out_valid_r  <= 1'b1;
              out_status_r <= pnrps_pkg::ST_BAD_RATE;
            end else begin
              epos_r[use_idx] <= pos_adv;
              if (use_p == '0) begin
                // new window: redraw the pick row
                row_r   <= '0;
                k_r     <= 8'd0;
                state_r <= S_DRAW;
              end else begin
                state_r <= S_READ;
              end
            end
          end
        end
        S_READ: begin
          state_r <= S_FIN;
        end
        S_FIN: begin
          out_valid_r <= 1'b1;
          out_take_r  <= rd_r[p_r];
          state_r     <= S_IDLE;
        end
        S_DRAW: begin
          if (k_r == t_r) begin
            out_valid_r <= 1'b1;
            out_take_r  <= row_r[0];
            state_r     <= S_IDLE;
          end else begin
            lfsr_r  <= lfsr_adv;
            state_r <= S_MODW;
          end
        end
        S_MODW: begin
          if (mod_rsp.done) begin
            row_r[mod_rsp.rem[PW-1:0]] <= 1'b1;
            k_r     <= k_r + 8'd1;
            state_r <= S_DRAW;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_take   = out_take_r;
  assign out_status = out_status_r;

endmodule

### test/tb_per_node_random_packet_sampler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_per_node_random_packet_sampler_top
// self-checking bench for the per-node random packet sampler: requests go
// through a queue-fed driver, a built-in predictor of the monitor table and
// draw lfsr computes each expected take/status, and a monitor compares every
// result strobe against the oldest prediction
// ----------------------------------------------------------------------------
module tb_per_node_random_packet_sampler_top;

  localparam int LIMIT = 20_000_000;
  localparam int NODES = pnrps_pkg::NODES;
  localparam int MAXW  = pnrps_pkg::MAX_WINDOW;

  typedef struct {
    logic        req_type;
    logic [31:0] node_addr;
    logic [7:0]  new_take;
    logic [7:0]  new_window;
  } request_t;

  typedef struct {
    logic               take;
    pnrps_pkg::status_t status;
  } verdict_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_req_type;
  logic [31:0] in_node_addr;
  logic [7:0]  in_new_take;
  logic [7:0]  in_new_window;
  logic        out_valid;
  logic        out_take;
  logic [1:0]  out_status;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [31:0] cfg_wdata;

  per_node_random_packet_sampler_top i_dut (.*);

  // predictor copy of the table and registers
  logic        mon_valid [NODES];
  logic [31:0] mon_addr [NODES];
  logic [7:0]  mon_take [NODES];
  logic [7:0]  mon_window [NODES];
  int unsigned mon_pos [NODES];
  logic        mon_pick [NODES][MAXW];
  logic [31:0] draw_state;
  logic [7:0]  dflt_take;
  logic [7:0]  dflt_window;

  request_t    request_q[$];
  verdict_t    verdict_q[$];
  request_t    cur;
  int          idle_left;
  bit          idling_on;
  int          errors;
  int          results_seen;
  int          status_seen [4];
  int          taken_cnt;
  longint      cycles;
  logic [31:0] addr_pool [20];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic verdict_t predict_verdict(request_t r);
    verdict_t    v;
    int          e;
    int unsigned t;
    int unsigned w;
    int unsigned p;
    v.take   = 1'b0;
    v.status = pnrps_pkg::ST_OK;
    e = -1;
    for (int i = NODES - 1; i >= 0; i--)
      if (mon_valid[i] && mon_addr[i] == r.node_addr) e = i;
    if (r.req_type == pnrps_pkg::REQ_RATE) begin
      if (e < 0) begin
        v.status = pnrps_pkg::ST_NOT_FOUND;
      end else begin
        mon_take[e]   = r.new_take;
        mon_window[e] = r.new_window;
        mon_pos[e]    = 0;
      end
      return v;
    end
    if (e < 0) begin
      for (int i = NODES - 1; i >= 0; i--)
        if (!mon_valid[i]) e = i;
      if (e >= 0) begin
        mon_valid[e]  = 1'b1;
        mon_addr[e]   = r.node_addr;
        mon_take[e]   = dflt_take;
        mon_window[e] = dflt_window;
        mon_pos[e]    = 0;
      end
    end
    if (e < 0) begin
      v.status = pnrps_pkg::ST_FULL;
      return v;
    end
    t = 32'(mon_take[e]);
    w = 32'(mon_window[e]);
    if (t == 0) begin
      v.take = 1'b0;
    end else if (t == w) begin
      v.take = 1'b1;
    end else if (t > w || w > MAXW) begin
      v.status = pnrps_pkg::ST_BAD_RATE;
    end else begin
      p = mon_pos[e];
      if (p >= w) p = 0;
      if (p == 0) begin
        for (int k = 0; k < MAXW; k++) mon_pick[e][k] = 1'b0;
        for (int k = 0; k < t; k++) begin
          draw_state = pnrps_pkg::lfsr_next(draw_state);
          mon_pick[e][draw_state % w] = 1'b1;
        end
      end
      v.take = mon_pick[e][p];
      p++;
      mon_pos[e] = (p >= w) ? 0 : p;
    end
    return v;
  endfunction

  // driver: start stays up until the request is accepted
  always @(posedge clk) begin
    logic fire;
    logic nxt;
    if (!rst_n) begin
      start         <= 1'b0;
      in_req_type   <= pnrps_pkg::REQ_PACKET;
      in_node_addr  <= '0;
      in_new_take   <= '0;
      in_new_window <= '0;
      idle_left     = 0;
    end else begin
      fire = start && !busy;
      nxt  = start;
      if (fire) verdict_q.push_back(predict_verdict(cur));
      if (!start || fire) begin
        if (idle_left > 0) begin
          idle_left--;
          nxt = 1'b0;
        end else if (request_q.size() > 0) begin
          cur = request_q.pop_front();
          in_req_type   <= cur.req_type;
          in_node_addr  <= cur.node_addr;
          in_new_take   <= cur.new_take;
          in_new_window <= cur.new_window;
          nxt = 1'b1;
          if (idling_on && $urandom_range(0, 5) == 0) idle_left = $urandom_range(1, 7);
        end else begin
          nxt = 1'b0;
        end
      end
      start <= nxt;
    end
  end

  // monitor
  always @(posedge clk) begin
    verdict_t v;
    if (rst_n && out_valid) begin
      results_seen++;
      status_seen[out_status]++;
      if (out_take) taken_cnt++;
      if (verdict_q.size() == 0) begin
        $display("%0t: result with nothing expected: take %0b status %0d",
                 $time, out_take, out_status);
        errors++;
      end else begin
        v = verdict_q.pop_front();
        if (out_take !== v.take) begin
          $display("%0t: take mismatch: expected %0b actual %0b", $time, v.take, out_take);
          errors++;
        end
        if (out_status !== v.status) begin
          $display("%0t: status mismatch: expected %0d actual %0d",
                   $time, v.status, out_status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d requests outstanding",
               cycles, verdict_q.size() + request_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic add_request(logic rq, logic [31:0] a, logic [7:0] t, logic [7:0] w);
    request_t r;
    r.req_type   = rq;
    r.node_addr  = a;
    r.new_take   = t;
    r.new_window = w;
    request_q.push_back(r);
  endtask

  task automatic drain();
    while (request_q.size() > 0 || start || verdict_q.size() > 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(pnrps_pkg::reg_idx_t idx, logic [31:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    case (idx)
      pnrps_pkg::REG_SEED: begin
        draw_state = data;
      end
      pnrps_pkg::REG_TAKE: begin
        dflt_take = data[7:0];
      end
      pnrps_pkg::REG_WINDOW: begin
        dflt_window = data[7:0];
      end
      default: begin
      end
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_requests(int n);
    int          pick;
    logic [31:0] a;
    logic [7:0]  t;
    logic [7:0]  w;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      a = ($urandom_range(0, 19) == 0) ? $urandom() : addr_pool[$urandom_range(0, 19)];
      if (pick < 75) begin
        add_request(pnrps_pkg::REQ_PACKET, a, 8'($urandom()), 8'($urandom()));
      end else begin
        w = 8'($urandom_range(1, MAXW));
        case ($urandom_range(0, 9))
          0: t = w;
          1: t = w + 8'($urandom_range(1, 20));
          2: begin
            t = 8'($urandom_range(0, 2));
            w = 8'd0;
          end
          3: t = 8'd0;
          4: begin
            t = 8'($urandom_range(1, 8));
            w = 8'($urandom_range(129, 255));
          end
          5: t = (w > 8'd40) ? 8'($urandom_range(20, 40)) : w - 8'd1;
          default: t = (w > 8'd8) ? 8'($urandom_range(1, 8)) : 8'($urandom_range(1, w));
        endcase
        add_request(pnrps_pkg::REQ_RATE, a, t, w);
      end
    end
  endtask

  initial begin
    logic [31:0] a0;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_idx     = pnrps_pkg::REG_SEED;
    cfg_wdata   = '0;
    idling_on   = 1'b1;
    errors      = 0;
    cycles      = 0;
    results_seen = 0;
    taken_cnt   = 0;
    for (int i = 0; i < 4; i++) status_seen[i] = 0;
    for (int i = 0; i < NODES; i++) begin
      mon_valid[i] = 1'b0;
      mon_pos[i]   = 0;
    end
    draw_state  = pnrps_pkg::SEED_RESET;
    dflt_take   = pnrps_pkg::TAKE_RESET;
    dflt_window = pnrps_pkg::WINDOW_RESET;
    for (int i = 0; i < 20; i++) addr_pool[i] = $urandom();
    a0 = addr_pool[0];
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults, then the rate corner cases on one monitor and on the all-ones and all-zero addresses
    add_request(pnrps_pkg::REQ_PACKET, a0, 8'h00, 8'h00);
    add_request(pnrps_pkg::REQ_PACKET, a0, 8'hff, 8'hff);
    add_request(pnrps_pkg::REQ_RATE, a0, 8'd0, 8'd0);
    add_request(pnrps_pkg::REQ_PACKET, a0, 8'd0, 8'd0);
    add_request(pnrps_pkg::REQ_RATE, a0, 8'd128, 8'd128);
    add_request(pnrps_pkg::REQ_PACKET, a0, 8'd0, 8'd0);
    add_request(pnrps_pkg::REQ_RATE, a0, 8'd5, 8'd3);
    add_request(pnrps_pkg::REQ_PACKET, a0, 8'd0, 8'd0);
    add_request(pnrps_pkg::REQ_RATE, a0, 8'd2, 8'd200);
    add_request(pnrps_pkg::REQ_PACKET, a0, 8'd0, 8'd0);
    add_request(pnrps_pkg::REQ_RATE, a0, 8'd200, 8'd200);
    add_request(pnrps_pkg::REQ_PACKET, a0, 8'd0, 8'd0);
    add_request(pnrps_pkg::REQ_RATE, a0, 8'd3, 8'd0);
    add_request(pnrps_pkg::REQ_PACKET, a0, 8'd0, 8'd0);
    add_request(pnrps_pkg::REQ_RATE, a0, 8'd3, 8'd4);
    for (int i = 0; i < 5; i++) add_request(pnrps_pkg::REQ_PACKET, a0, 8'd0, 8'd0);
    add_request(pnrps_pkg::REQ_RATE, 32'hffff_ffff, 8'd1, 8'd1);
    add_request(pnrps_pkg::REQ_PACKET, 32'h0000_0000, 8'd0, 8'd0);
    add_request(pnrps_pkg::REQ_RATE, 32'h0000_0000, 8'd1, 8'd128);
    add_request(pnrps_pkg::REQ_PACKET, 32'h0000_0000, 8'd0, 8'd0);
    drain();

    // default setting extremes, each phase allocating a few monitors
    write_reg(pnrps_pkg::REG_SEED, 32'hffff_ffff);
    write_reg(pnrps_pkg::REG_TAKE, 32'd0);
    write_reg(pnrps_pkg::REG_WINDOW, 32'd1);
    random_requests(120);
    drain();

    // zero seed: every draw lands on position zero
    write_reg(pnrps_pkg::REG_SEED, 32'd0);
    write_reg(pnrps_pkg::REG_TAKE, 32'd3);
    write_reg(pnrps_pkg::REG_WINDOW, 32'd128);
    random_requests(120);
    drain();

    write_reg(pnrps_pkg::REG_SEED, $urandom() | 32'd1);
    write_reg(pnrps_pkg::REG_TAKE, 32'd128);
    write_reg(pnrps_pkg::REG_WINDOW, 32'd128);
    random_requests(150);
    drain();

    write_reg(pnrps_pkg::REG_SEED, $urandom() | 32'h8000_0000);
    write_reg(pnrps_pkg::REG_TAKE, 32'd4);
    write_reg(pnrps_pkg::REG_WINDOW, 32'd16);
    random_requests(900);
    drain();

    // closing stretch back to back
    idling_on = 1'b0;
    write_reg(pnrps_pkg::REG_SEED, $urandom() | 32'd1);
    random_requests(240);
    drain();
    repeat (50) @(negedge clk);

    $display("%0d results checked: %0d ok, %0d not found, %0d table full, %0d bad rate",
             results_seen, status_seen[pnrps_pkg::ST_OK],
             status_seen[pnrps_pkg::ST_NOT_FOUND],
             status_seen[pnrps_pkg::ST_FULL], status_seen[pnrps_pkg::ST_BAD_RATE]);
    $display("%0d packets taken, %0d mismatches, %0d cycles", taken_cnt, errors, cycles);
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
